@@ rtl/dlm_pkg.sv @@
package dlm_pkg;

	localparam int IN_MAX_D  = 64;
	localparam int OUT_MAX_D = 16;
	localparam int BATCH_D   = 32;
	localparam int ACC_W     = 40;

	typedef enum logic [2:0] {
		REQ_WEIGHT_WR = 3'd0,
		REQ_BIAS_WR   = 3'd1,
		REQ_FORWARD   = 3'd2,
		REQ_STORE_ACT = 3'd3,
		REQ_STORE_GRD = 3'd4,
		REQ_Q_WGRAD   = 3'd5,
		REQ_Q_BGRAD   = 3'd6,
		REQ_Q_IGRAD   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		KIND_LOGIT = 2'd0,
		KIND_WGRAD = 2'd1,
		KIND_BGRAD = 2'd2,
		KIND_IGRAD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ADDR_IN_SIZE  = 2'd0,
		ADDR_OUT_SIZE = 2'd1
	} cfg_addr_t;

	// compute job handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [3:0] row;
		logic [5:0] col;
		logic [4:0] smp;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RUN  = 2'd1,
		ST_DRN  = 2'd2,
		ST_EMIT = 2'd3
	} st_t;

endpackage

@@ rtl/dlm_front.sv @@
module dlm_front import dlm_pkg::*; #(
	parameter int IN_MAX  = IN_MAX_D,
	parameter int OUT_MAX = OUT_MAX_D,
	parameter int BATCH   = BATCH_D
) (
	input  logic        acc_in,
	input  logic [2:0]  req_type,
	input  logic [3:0]  row,
	input  logic [5:0]  col,
	input  logic [4:0]  sample,
	input  logic [6:0]  ni,
	input  logic [6:0]  no,
	input  logic        last,
	output logic        job_v,
	output job_t        job,
	output logic        wr_w,
	output logic        wr_b,
	output logic        wr_f,
	output logic        wr_a,
	output logic        wr_g
);
	logic row_ok, col_ok, smp_ok;
	req_t rq;

	assign rq     = req_t'(req_type);
	assign row_ok = {28'd0, row} < OUT_MAX;
	assign col_ok = {26'd0, col} < IN_MAX;
	assign smp_ok = {27'd0, sample} < BATCH;

	assign wr_w = acc_in && rq == REQ_WEIGHT_WR && row_ok && col_ok;
	assign wr_b = acc_in && rq == REQ_BIAS_WR && row_ok;
	assign wr_f = acc_in && rq == REQ_FORWARD && col_ok;
	assign wr_a = acc_in && rq == REQ_STORE_ACT && smp_ok && col_ok;
	assign wr_g = acc_in && rq == REQ_STORE_GRD && smp_ok && row_ok;

	always_comb begin
		job_v = 1'b0;
		job.kind = KIND_LOGIT;
		job.row = row;
		job.col = col;
		job.smp = sample;
		case (rq)
			REQ_FORWARD: begin
				job_v = acc_in && last;
			end
			REQ_Q_WGRAD: begin
				job.kind = KIND_WGRAD;
				job_v = acc_in && {3'd0, row} < no && {1'b0, col} < ni;
			end
			REQ_Q_BGRAD: begin
				job.kind = KIND_BGRAD;
				job_v = acc_in && {3'd0, row} < no;
			end
			REQ_Q_IGRAD: begin
				job.kind = KIND_IGRAD;
				job_v = acc_in && smp_ok && {1'b0, col} < ni;
			end
			default: job_v = 1'b0;
		endcase
	end
endmodule

@@ rtl/dlm_queue.sv @@
module dlm_queue import dlm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic nempty,
	output logic full,
	output job_t head
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign nempty = cnt_q != 2'd0;
	assign full   = cnt_q == 2'd2;
	assign head   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ rtl/dlm_back.sv @@
module dlm_back import dlm_pkg::*; #(
	parameter int IN_MAX  = IN_MAX_D,
	parameter int OUT_MAX = OUT_MAX_D,
	parameter int BATCH   = BATCH_D,
	localparam int IW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1,
	localparam int OW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1,
	localparam int BW = (BATCH > 1) ? $clog2(BATCH) : 1,
	localparam int CW = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_w,
	input  logic               wr_b,
	input  logic               wr_f,
	input  logic               wr_a,
	input  logic               wr_g,
	input  logic [3:0]         w_row,
	input  logic [5:0]         w_col,
	input  logic [4:0]         w_smp,
	input  logic signed [15:0] w_val,
	input  logic [6:0]         ni,
	input  logic [6:0]         no,
	input  logic               job_v,
	input  job_t               job,
	output logic               job_pop,
	output logic               res_v,
	output logic [1:0]         res_kind,
	output logic [5:0]         res_index,
	output logic signed [15:0] res_value,
	output logic               res_sat,
	output logic               res_end,
	output logic               busy
);
	logic [15:0] wmem   [OUT_MAX*IN_MAX];
	logic [15:0] fvec   [IN_MAX];
	logic [15:0] amem   [BATCH*IN_MAX];
	logic [15:0] gmem   [BATCH*OUT_MAX];
	logic [15:0] bias_q [OUT_MAX];

	st_t st_q, st_n;
	job_t cur_q;
	logic [CW-1:0] k_q, i_q;
	logic [CW-1:0] klen;
	logic rd_v_s1, rd_v_s2;
	logic signed [15:0] a_s1, b_s1;
	logic signed [31:0] p_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [OW-1:0] orow;
	logic [IW-1:0] fcol;

	// walk length: forward = ni, wgrad/bgrad = BATCH, igrad = no
	always_comb begin
		case (cur_q.kind)
			KIND_LOGIT: klen = {2'd0, ni};
			KIND_IGRAD: klen = {2'd0, no};
			default: klen = CW'(BATCH);
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_w) wmem[{w_row[OW-1:0], w_col[IW-1:0]}] <= w_val;
		if (wr_f) fvec[w_col[IW-1:0]] <= w_val;
		if (wr_a) amem[{w_smp[BW-1:0], w_col[IW-1:0]}] <= w_val;
		if (wr_g) gmem[{w_smp[BW-1:0], w_row[OW-1:0]}] <= w_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < OUT_MAX; j++) bias_q[j] <= '0;
		end else if (wr_b) begin
			bias_q[w_row[OW-1:0]] <= w_val;
		end
	end

	assign orow = (cur_q.kind == KIND_LOGIT) ? i_q[OW-1:0] : cur_q.row[OW-1:0];
	assign fcol = k_q[IW-1:0];

	// stage 1: memory reads
	always_ff @(posedge clk) begin
		case (cur_q.kind)
			KIND_LOGIT: begin
				a_s1 <= wmem[{orow, fcol}];
				b_s1 <= fvec[fcol];
			end
			KIND_WGRAD: begin
				a_s1 <= gmem[{k_q[BW-1:0], orow}];
				b_s1 <= amem[{k_q[BW-1:0], cur_q.col[IW-1:0]}];
			end
			KIND_BGRAD: begin
				a_s1 <= gmem[{k_q[BW-1:0], orow}];
				b_s1 <= 16'sd1;
			end
			default: begin
				a_s1 <= gmem[{cur_q.smp[BW-1:0], k_q[OW-1:0]}];
				b_s1 <= wmem[{k_q[OW-1:0], cur_q.col[IW-1:0]}];
			end
		endcase
		p_s2 <= a_s1 * b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
			rd_v_s2 <= 1'b0;
			k_q <= '0;
			i_q <= '0;
			acc_q <= '0;
			cur_q <= '0;
		end else begin
			st_q <= st_n;
			rd_v_s1 <= (st_q == ST_RUN);
			rd_v_s2 <= rd_v_s1;
			if (st_q == ST_IDLE && job_v) begin
				cur_q <= job;
				k_q <= '0;
				i_q <= '0;
				acc_q <= (job.kind == KIND_LOGIT)
				         ? ACC_W'($signed(bias_q[0])) <<< 8 : '0;
			end else if (st_q == ST_RUN) begin
				k_q <= k_q + 1'b1;
			end else if (st_q == ST_EMIT) begin
				k_q <= '0;
				i_q <= i_q + 1'b1;
				acc_q <= ACC_W'($signed(bias_q[i_q[OW-1:0] + 1'b1])) <<< 8;
			end
			if (rd_v_s2) acc_q <= acc_q + ACC_W'(p_s2);
		end
	end

	always_comb begin
		st_n = st_q;
		job_pop = 1'b0;
		case (st_q)
			ST_IDLE: if (job_v) begin
				st_n = ST_RUN;
				job_pop = 1'b1;
			end
			ST_RUN: if (k_q == klen - 1'b1) st_n = ST_DRN;
			ST_DRN: if (!rd_v_s1 && !rd_v_s2) st_n = ST_EMIT;
			ST_EMIT: begin
				if (cur_q.kind == KIND_LOGIT && i_q != {2'd0, no} - 1'b1) st_n = ST_RUN;
				else st_n = ST_IDLE;
			end
			default: st_n = ST_IDLE;
		endcase
	end

	// rounding: floor((2x+d)/(2d)) with d a power of two
	logic signed [ACC_W+1:0] rnd;
	logic signed [ACC_W+1:0] q;
	always_comb begin
		case (cur_q.kind)
			KIND_WGRAD: begin
				rnd = (ACC_W+2)'(acc_q) + (ACC_W+2)'(BATCH*128);
				q = rnd >>> ($clog2(BATCH) + 8);
			end
			KIND_BGRAD: begin
				rnd = (ACC_W+2)'(acc_q) + (ACC_W+2)'(BATCH/2);
				rnd = (BATCH == 1) ? (ACC_W+2)'(acc_q) : rnd;
				q = rnd >>> $clog2(BATCH);
			end
			default: begin
				rnd = (ACC_W+2)'(acc_q) + (ACC_W+2)'(128);
				q = rnd >>> 8;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v <= 1'b0;
		end else begin
			res_v <= (st_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_EMIT) begin
			res_kind <= cur_q.kind;
			case (cur_q.kind)
				KIND_LOGIT: res_index <= 6'(i_q);
				KIND_BGRAD: res_index <= {2'd0, cur_q.row};
				default: res_index <= cur_q.col;
			endcase
			if (q > 32767) begin
				res_value <= 16'sh7fff;
				res_sat <= 1'b1;
			end else if (q < -32768) begin
				res_value <= -16'sh8000;
				res_sat <= 1'b1;
			end else begin
				res_value <= q[15:0];
				res_sat <= 1'b0;
			end
			res_end <= (st_n == ST_IDLE);
		end
	end

	assign busy = st_q != ST_IDLE;
endmodule

@@ rtl/dense_layer_mac_engine.sv @@
// channel | signals                                   | handshake
// in      | req_type row col sample value last        | start && !busy
// out     | result_kind index result_value saturated  | strobe, one cycle
//         | end_of_run                                |
// cfg     | psel penable pwrite paddr pwdata prdata   | APB, pready high
// Stores are written at the accepting edge. A compute item is registered in
// the job queue, then walks N MACs, one per cycle, through a two-deep
// read/multiply pipe, drains the pipe and emits; N = in_size per logit,
// BATCH per weight or bias grad, out_size per input grad. Reset clears the
// control state and biases at once and sets in_size to 64, out_size to 16.
// busy holds while a compute job is queued or running and drops in the cycle
// of the last result.
module dense_layer_mac_engine import dlm_pkg::*; #(
	parameter int IN_MAX  = IN_MAX_D,
	parameter int OUT_MAX = OUT_MAX_D,
	parameter int BATCH   = BATCH_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [3:0]  row,
	input  logic [5:0]  col,
	input  logic [4:0]  sample,
	input  logic signed [15:0] value,
	input  logic        last,
	output logic        strobe,
	output logic [1:0]  result_kind,
	output logic [5:0]  index,
	output logic signed [15:0] result_value,
	output logic        saturated,
	output logic        end_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [6:0] in_size_q;
	logic [4:0] out_size_q;
	logic [6:0] ni, no;
	logic acc_in, job_v, qn, qfull, pop, bbusy;
	logic wr_w, wr_b, wr_f, wr_a, wr_g;
	job_t job, head;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_size_q <= 7'd64;
			out_size_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			case (cfg_addr_t'(paddr[2]))
				ADDR_IN_SIZE: in_size_q <= pwdata[6:0];
				default: out_size_q <= pwdata[4:0];
			endcase
		end
	end
	always_comb begin
		case (cfg_addr_t'(paddr[2]))
			ADDR_IN_SIZE: prdata = {25'd0, in_size_q};
			default: prdata = {27'd0, out_size_q};
		endcase
	end

	assign ni = (in_size_q == 0) ? 7'd1
	            : ({25'd0, in_size_q} > IN_MAX) ? 7'(IN_MAX) : in_size_q;
	assign no = (out_size_q == 0) ? 7'd1
	            : ({27'd0, out_size_q} > OUT_MAX) ? 7'(OUT_MAX) : {2'd0, out_size_q};

	// one compute job at a time in flight keeps later stores ordered
	assign busy = qn || bbusy;
	assign acc_in = start && !busy;

	dlm_front #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX), .BATCH(BATCH)) u_front (
		.acc_in, .req_type, .row, .col, .sample, .ni, .no, .last,
		.job_v, .job, .wr_w, .wr_b, .wr_f, .wr_a, .wr_g
	);

	dlm_queue u_queue (
		.clk, .arst_n, .push(job_v && !qfull), .push_job(job), .pop,
		.nempty(qn), .full(qfull), .head
	);

	dlm_back #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX), .BATCH(BATCH)) u_back (
		.clk, .arst_n, .wr_w, .wr_b, .wr_f, .wr_a, .wr_g,
		.w_row(row), .w_col(col), .w_smp(sample), .w_val(value), .ni, .no,
		.job_v(qn), .job(head), .job_pop(pop),
		.res_v(strobe), .res_kind(result_kind), .res_index(index),
		.res_value(result_value), .res_sat(saturated), .res_end(end_of_run),
		.busy(bbusy)
	);
endmodule

@@ rtl/dlm_checker.sv @@
module dlm_checker import dlm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic strobe,
	input logic saturated,
	input logic end_of_run,
	input logic [1:0] result_kind,
	input logic signed [15:0] result_value,
	input logic pready
);
	a_sat_val: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && saturated |-> result_value == 16'sh7fff || result_value == -16'sh8000)
		else $error("saturated flag without clipped value");
	a_grad_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_kind != KIND_LOGIT |-> end_of_run)
		else $error("gradient result without end_of_run");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !end_of_run |-> busy)
		else $error("mid-run result while idle");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind dense_layer_mac_engine dlm_checker u_chk (
	.clk, .arst_n, .busy, .strobe, .saturated, .end_of_run,
	.result_kind, .result_value, .pready
);

@@ tb/testbench.sv @@
module testbench;
	import dlm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE = 80;

	typedef struct {
		kind_t       kind;
		logic [5:0]  idx;
		logic [15:0] val;
		logic        sat;
		logic        eor;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [2:0] req_type = '0;
	logic [3:0] row = '0;
	logic [5:0] col = '0;
	logic [4:0] sample = '0;
	logic signed [15:0] value = '0;
	logic last = 0;
	logic strobe;
	logic [1:0] result_kind;
	logic [5:0] index;
	logic signed [15:0] result_value;
	logic saturated, end_of_run;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	dense_layer_mac_engine dut (.*);

	always #10 clk = ~clk;

	// mirror of the layer, with a written mark per weight, feature, activation and gradient entry
	logic signed [15:0] wmem [16][64];
	logic signed [15:0] bmem [16];
	logic signed [15:0] fvec [64];
	logic signed [15:0] amem [32][64];
	logic signed [15:0] gmem [32][16];
	bit w_ok [16][64];
	bit f_ok [64];
	bit a_ok [32][64];
	bit g_ok [32][16];
	logic [6:0] in_size_r = 64;
	logic [4:0] out_size_r = 16;

	result_t pending[$];
	int errors = 0;
	int idle_pct = 36;
	int sent = 0;
	int cyc = 0, act_cyc = 0;

	function automatic int n_in();
		if (in_size_r == 0) return 1;
		return (in_size_r > 64) ? 64 : in_size_r;
	endfunction

	function automatic int n_out();
		if (out_size_r == 0) return 1;
		return (out_size_r > 16) ? 16 : out_size_r;
	endfunction

	// round to nearest (ties up) after dividing by 2**sh, then clip to Q8.8
	function automatic result_t make_result(kind_t k, logic [5:0] i, longint acc, int sh,
			logic e);
		result_t r;
		longint q;
		q = (2 * acc + (longint'(1) <<< sh)) >>> (sh + 1);
		r.kind = k;
		r.idx = i;
		r.sat = 0;
		r.eor = e;
		if (q > 32767) begin
			q = 32767;
			r.sat = 1;
		end else if (q < -32768) begin
			q = -32768;
			r.sat = 1;
		end
		r.val = q[15:0];
		return r;
	endfunction

	// true when the item reads only entries written before it or by the item itself
	function automatic bit readable(req_t rq, logic [3:0] r, logic [5:0] c, logic [4:0] s,
			logic lst);
		int ni, no;
		bit ok;
		ni = n_in();
		no = n_out();
		ok = 1;
		case (rq)
			REQ_FORWARD: if (lst) begin
				for (int i = 0; i < no; i++)
					for (int k = 0; k < ni; k++)
						if (!w_ok[i][k] || !(f_ok[k] || k == c)) ok = 0;
			end
			REQ_Q_WGRAD: if (r < no && c < ni) begin
				for (int k = 0; k < 32; k++)
					if (!g_ok[k][r] || !a_ok[k][c]) ok = 0;
			end
			REQ_Q_BGRAD: if (r < no) begin
				for (int k = 0; k < 32; k++)
					if (!g_ok[k][r]) ok = 0;
			end
			REQ_Q_IGRAD: if (c < ni) begin
				for (int i = 0; i < no; i++)
					if (!g_ok[s][i] || !w_ok[i][c]) ok = 0;
			end
			default: ok = 1;
		endcase
		return ok;
	endfunction

	task automatic predict_layer(req_t rq, logic [3:0] r, logic [5:0] c, logic [4:0] s,
			logic signed [15:0] v, logic lst);
		longint acc;
		int ni, no;
		ni = n_in();
		no = n_out();
		acc = 0;
		case (rq)
			REQ_WEIGHT_WR: begin
				wmem[r][c] = v;
				w_ok[r][c] = 1;
			end
			REQ_BIAS_WR:   bmem[r] = v;
			REQ_STORE_ACT: begin
				amem[s][c] = v;
				a_ok[s][c] = 1;
			end
			REQ_STORE_GRD: begin
				gmem[s][r] = v;
				g_ok[s][r] = 1;
			end
			REQ_FORWARD: begin
				fvec[c] = v;
				f_ok[c] = 1;
				if (lst) begin
					for (int i = 0; i < no; i++) begin
						acc = longint'(bmem[i]) * 256;
						for (int k = 0; k < ni; k++)
							acc += longint'(wmem[i][k]) * longint'(fvec[k]);
						pending.push_back(make_result(KIND_LOGIT, 6'(i), acc, 8, i == no - 1));
					end
				end
			end
			REQ_Q_WGRAD: if (r < no && c < ni) begin
				for (int k = 0; k < 32; k++)
					acc += longint'(gmem[k][r]) * longint'(amem[k][c]);
				pending.push_back(make_result(KIND_WGRAD, c, acc, 13, 1));
			end
			REQ_Q_BGRAD: if (r < no) begin
				for (int k = 0; k < 32; k++)
					acc += longint'(gmem[k][r]);
				pending.push_back(make_result(KIND_BGRAD, 6'(r), acc, 5, 1));
			end
			default: if (c < ni) begin
				for (int i = 0; i < no; i++)
					acc += longint'(gmem[s][i]) * longint'(wmem[i][c]);
				pending.push_back(make_result(KIND_IGRAD, c, acc, 8, 1));
			end
		endcase
	endtask

	// leaves start high; the next call in the same step replaces the item
	task automatic send_item(req_t rq, logic [3:0] r, logic [5:0] c, logic [4:0] s,
			logic signed [15:0] v, logic lst);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		req_type <= rq;
		row <= r;
		col <= c;
		sample <= s;
		value <= v;
		last <= lst;
		do @(posedge clk); while (busy);
		act_cyc = cyc;
		sent++;
		predict_layer(rq, r, c, s, v, lst);
	endtask

	task automatic try_item(req_t rq, logic [3:0] r, logic [5:0] c, logic [4:0] s,
			logic signed [15:0] v, logic lst);
		if (readable(rq, r, c, s, lst)) send_item(rq, r, c, s, v, lst);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_addr_t a, logic [31:0] d);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {a, 1'b0} << 1;
		pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (a == ADDR_IN_SIZE) in_size_r = d[6:0];
		else out_size_r = d[4:0];
		@(posedge clk);
	endtask

	task automatic cfg_check(cfg_addr_t a, logic [31:0] d);
		psel <= 1;
		penable <= 0;
		pwrite <= 0;
		paddr <= {a, 1'b0} << 1;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata !== d || pready !== 1'b1) begin
			if (errors < 10)
				$display("register read: exp %0d got %0d ready %0d", d, prdata, pready);
			errors++;
		end
		psel <= 0;
		penable <= 0;
		@(posedge clk);
	endtask

	task automatic set_shape(logic [31:0] ni, logic [31:0] no);
		drain();
		cfg_write(ADDR_IN_SIZE, ni);
		cfg_write(ADDR_OUT_SIZE, no);
		cfg_check(ADDR_IN_SIZE, {25'd0, in_size_r});
		cfg_check(ADDR_OUT_SIZE, {27'd0, out_size_r});
	endtask

	function automatic logic [15:0] rand_val();
		if ($urandom_range(1)) return 16'($signed($urandom_range(1023)) - 512);
		return 16'($urandom);
	endfunction

	// fills the entries that the later queries read, on a 2 x 2 layer
	task automatic test_fill();
		set_shape(2, 2);
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < 2; c++)
				try_item(REQ_WEIGHT_WR, 4'(r), 6'(c), '0, rand_val(), 0);
		for (int c = 0; c < 2; c++)
			try_item(REQ_FORWARD, '0, 6'(c), '0, rand_val(), 0);
		idle_pct = 0;
		for (int s = 0; s < 32; s++) begin
			try_item(REQ_STORE_ACT, '0, 6'd0, 5'(s), rand_val(), 0);
			try_item(REQ_STORE_GRD, 4'd0, '0, 5'(s), rand_val(), 0);
		end
		idle_pct = 36;
		try_item(REQ_STORE_GRD, 4'd1, '0, 5'd0, rand_val(), 0);
		try_item(REQ_STORE_GRD, 4'd1, '0, 5'd31, rand_val(), 0);
	endtask

	task automatic test_directed();
		// logit with zero biases, then extreme biases and weights
		try_item(REQ_FORWARD, '0, 6'd1, '0, 16'sh7fff, 1);
		try_item(REQ_BIAS_WR, 4'd0, '0, '0, 16'sh7fff, 0);
		try_item(REQ_BIAS_WR, 4'd1, '0, '0, -16'sh8000, 0);
		try_item(REQ_WEIGHT_WR, 4'd0, 6'd0, '0, -16'sh8000, 0);
		try_item(REQ_FORWARD, '0, 6'd0, '0, -16'sh8000, 0);
		try_item(REQ_FORWARD, '0, 6'd1, '0, 16'sh0001, 1);
		try_item(REQ_Q_WGRAD, 4'd0, 6'd0, '0, '0, 0);
		try_item(REQ_Q_WGRAD, 4'd0, 6'd5, '0, '0, 0);
		try_item(REQ_Q_BGRAD, 4'd15, '0, '0, '0, 0);
		try_item(REQ_Q_BGRAD, 4'd0, '0, '0, '0, 0);
		try_item(REQ_Q_IGRAD, '0, 6'd0, 5'd0, '0, 0);
		try_item(REQ_Q_IGRAD, '0, 6'd1, 5'd31, '0, 0);
		try_item(REQ_STORE_GRD, 4'd0, '0, 5'd0, 16'sh7fff, 0);
		try_item(REQ_STORE_ACT, '0, 6'd0, 5'd0, -16'sh8000, 0);
		try_item(REQ_Q_WGRAD, 4'd0, 6'd0, '0, '0, 0);
	endtask

	// small and out-of-range register values, plus queries beyond the shape
	task automatic test_shapes();
		logic [31:0] shapes [6][2] = '{'{1, 1}, '{0, 0}, '{127, 31}, '{100, 20},
			'{5, 3}, '{2, 2}};
		for (int p = 0; p < 6; p++) begin
			set_shape(shapes[p][0], shapes[p][1]);
			try_item(REQ_FORWARD, '0, 6'd0, '0, rand_val(), 1);
			try_item(REQ_Q_WGRAD, 4'd15, 6'd63, '0, '0, 0);
			try_item(REQ_Q_WGRAD, 4'd0, 6'd0, '0, '0, 0);
			try_item(REQ_Q_BGRAD, 4'd0, '0, '0, '0, 0);
			try_item(REQ_Q_IGRAD, '0, 6'd0, 5'd0, '0, 0);
		end
	endtask

	task automatic test_random();
		int goal;
		goal = sent + 12;
		while (sent < goal)
			try_item(req_t'($urandom_range(7)), 4'($urandom_range(2)),
				6'($urandom_range(2)), 5'($urandom), rand_val(), 1'($urandom));
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc - act_cyc > STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && strobe) begin
			act_cyc = cyc;
			if (pending.size() == 0) begin
				if (errors < 10)
					$display("unexpected result kind=%0d idx=%0d val=%0d", result_kind, index,
						result_value);
				errors++;
			end else begin
				e = pending.pop_front();
				if (result_kind !== e.kind || index !== e.idx || result_value !== e.val ||
						saturated !== e.sat || end_of_run !== e.eor) begin
					if (errors < 10)
						$display("mismatch: exp k=%0d i=%0d v=%0d s=%0d e=%0d got k=%0d i=%0d v=%0d s=%0d e=%0d",
							e.kind, e.idx, $signed(e.val), e.sat, e.eor, result_kind, index,
							result_value, saturated, end_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int r = 0; r < 16; r++) bmem[r] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_fill();
		test_directed();
		test_shapes();
		test_random();
		drain();
		if (errors == 0 && pending.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
